>>> src/lmks_pkg.sv
// shared types, constants and codes for the lattice motor kinetic step core
`timescale 1ns / 1ps
`default_nettype none

package lmks_pkg;

  // storage sizes
  localparam int MAX_PARTICLES = 256;
  localparam int LATTICE_SITES = 8192;
  localparam int PART_W        = $clog2(MAX_PARTICLES);
  localparam int SITE_W        = $clog2(LATTICE_SITES);
  localparam int LEN_W         = SITE_W + 1;

  // field widths
  localparam int WEIGHT_W  = 20;
  localparam int DRAW_W    = 20;
  localparam int ACC_W     = WEIGHT_W + 2;
  localparam int CFG_IDX_W = 2;
  localparam int EV_W      = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIND_WEIGHT    = 2'd0,
    CFG_UNBIND_WEIGHT  = 2'd1,
    CFG_STEP_WEIGHT    = 2'd2,
    CFG_LATTICE_LENGTH = 2'd3
  } cfg_idx_t;

  // item kinds
  typedef enum logic {
    OP_PLACE  = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  // result events
  typedef enum logic [EV_W-1:0] {
    EV_NONE   = 3'd0,
    EV_BIND   = 3'd1,
    EV_UNBIND = 3'd2,
    EV_STEP   = 3'd3,
    EV_PLACE  = 3'd4
  } ev_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_OCC0,
    ST_OCC1,
    ST_BIND,
    ST_UNBIND,
    ST_STEP,
    ST_APPLY,
    ST_STEP2,
    ST_PLACE,
    ST_DONE
  } st_t;

  // control of the shared accumulate and compare unit
  typedef struct packed {
    logic                clr;
    logic                add;
    logic [WEIGHT_W-1:0] weight;
  } cmp_ctl_t;

endpackage

`default_nettype wire

>>> src/lattice_motor_kinetic_step_core.sv
// top level of the lattice motor kinetic step core: sequencer, stores and result register
`timescale 1ns / 1ps
`default_nettype none

// Monte Carlo step engine for motor particles on a one-dimensional lattice with
// binding, unbinding and forward steps. Each input beat is either a place (opcode 0)
// or a kinetic update (opcode 1) for one particle and gives exactly one result beat.
// Items are handled one at a time: a place reads the particle and the occupancy of
// its target site, then, unless the site is taken, writes both stores; an update
// reads the particle and the occupancy of its site and the next site, tests the bind,
// unbind and step thresholds in that order and writes back any outcome. The particle
// table and the occupancy memory are read one entry per cycle with registered data
// and written one entry per cycle, and the shared accumulate and compare unit tests
// the thresholds one per cycle. After reset the occupancy memory and the particle
// table are swept to zero, during which in_tready stays low; configuration writes are
// taken at any time. A finished result waits in the output register while the next item is already accepted.
module lattice_motor_kinetic_step_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // particle_index[7:0], site[20:8], random_draw[40:21]
  input  wire logic [0:0]  in_tuser,   // opcode[0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // particle_out[7:0], position_out[20:8], bound_out[21]
  output logic [2:0]       out_tuser,  // event_res[2:0]
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  localparam int PW = lmks_pkg::PART_W;
  localparam int SW = lmks_pkg::SITE_W;
  localparam int LW = lmks_pkg::LEN_W;
  localparam int WW = lmks_pkg::WEIGHT_W;
  localparam int DW = lmks_pkg::DRAW_W;

  // configuration registers
  logic [WW-1:0] bind_w_r;
  logic [WW-1:0] unbind_w_r;
  logic [WW-1:0] step_w_r;
  logic [LW-1:0] len_r;

  // sequencer state and item registers
  lmks_pkg::st_t             state_r, state_nxt;
  lmks_pkg::op_t             op_r;
  logic [PW-1:0]             p_r;
  logic [SW-1:0]             tgt_r;
  logic [DW-1:0]             draw_r;
  logic [SW-1:0]             pos_r, pos_nxt;
  logic                      bnd_r, bnd_nxt;
  logic                      occ0_r, occ0_nxt;
  logic                      occ1_r, occ1_nxt;
  lmks_pkg::ev_t             ev_r, ev_nxt;
  logic [SW-1:0]             clr_r, clr_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic [PW-1:0]             out_p_r;
  logic [SW-1:0]             out_pos_r;
  logic                      out_bnd_r;
  lmks_pkg::ev_t             out_ev_r;
  logic                      out_load;

  // store ports
  logic                      occ_we;
  logic [SW-1:0]             occ_waddr;
  logic [0:0]                occ_wdata;
  logic [SW-1:0]             occ_raddr;
  logic [0:0]                occ_rdata;
  logic                      site_we;
  logic [PW-1:0]             site_waddr;
  logic [SW:0]               site_wdata;  // position[12:0], bound[13]
  logic [SW:0]               site_rdata;  // position[12:0], bound[13]

  // shared compare unit
  lmks_pkg::cmp_ctl_t        cmp_ctl;
  logic                      cmp_hit;

  // derived values
  logic                      in_acc;
  logic                      bound_cur;
  logic [LW-1:0]             nxt_site;
  logic [LW-1:0]             limit;
  logic                      step_ok;
  logic                      own;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == lmks_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign bound_cur = bnd_r;
  assign nxt_site  = {1'b0, pos_r} + LW'(1);
  assign limit     = (len_r > LW'(lmks_pkg::LATTICE_SITES)) ?
                     LW'(lmks_pkg::LATTICE_SITES) : len_r;
  assign step_ok   = bound_cur && (nxt_site < limit) && !occ1_r;
  assign own       = bound_cur && (pos_r == tgt_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bind_w_r   <= '0;
      unbind_w_r <= '0;
      step_w_r   <= '0;
      len_r      <= LW'(lmks_pkg::LATTICE_SITES);
    end else if (cfg_valid && cfg_ready) begin
      case (lmks_pkg::cfg_idx_t'(cfg_index))
        lmks_pkg::CFG_BIND_WEIGHT:    bind_w_r   <= cfg_data;
        lmks_pkg::CFG_UNBIND_WEIGHT:  unbind_w_r <= cfg_data;
        lmks_pkg::CFG_STEP_WEIGHT:    step_w_r   <= cfg_data;
        lmks_pkg::CFG_LATTICE_LENGTH: len_r      <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // particle table: position and bound flag, swept to zero after reset
  lmks_ram #(.WIDTH(SW + 1), .DEPTH(lmks_pkg::MAX_PARTICLES)) u_site_ram (
    .clk   (clk),
    .we    (site_we),
    .waddr (site_waddr),
    .wdata (site_wdata),
    .raddr (p_r),
    .rdata (site_rdata)
  );

  // site occupancy store, swept to zero after reset
  lmks_ram #(.WIDTH(1), .DEPTH(lmks_pkg::LATTICE_SITES)) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  lmks_cmp_unit u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cmp_ctl),
    .draw  (draw_r),
    .hit   (cmp_hit)
  );

  // next state and store controls
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    bnd_nxt     = bnd_r;
    occ0_nxt    = occ0_r;
    occ1_nxt    = occ1_r;
    ev_nxt      = ev_r;
    clr_nxt     = clr_r;
    occ_we      = 1'b0;
    occ_waddr   = pos_r;
    occ_wdata   = 1'b0;
    occ_raddr   = pos_r;
    site_we     = 1'b0;
    site_waddr  = p_r;
    site_wdata  = {bnd_r, tgt_r};
    cmp_ctl     = '0;
    out_load    = 1'b0;
    case (state_r)
      lmks_pkg::ST_CLEAR: begin
        occ_we     = 1'b1;
        occ_waddr  = clr_r;
        occ_wdata  = 1'b0;
        site_we    = 1'b1;
        site_waddr = clr_r[PW-1:0];
        site_wdata = '0;
        clr_nxt    = clr_r + SW'(1);
        if (clr_r == SW'(lmks_pkg::LATTICE_SITES - 1)) begin
          state_nxt = lmks_pkg::ST_IDLE;
        end
      end
      lmks_pkg::ST_IDLE: begin
        if (in_acc) begin
          ev_nxt    = lmks_pkg::EV_NONE;
          state_nxt = lmks_pkg::ST_FETCH;
        end
      end
      lmks_pkg::ST_FETCH: begin
        state_nxt = lmks_pkg::ST_OCC0;
      end
      lmks_pkg::ST_OCC0: begin
        pos_nxt   = site_rdata[SW-1:0];
        bnd_nxt   = site_rdata[SW];
        occ_raddr = (op_r == lmks_pkg::OP_PLACE) ? tgt_r : site_rdata[SW-1:0];
        state_nxt = lmks_pkg::ST_OCC1;
      end
      lmks_pkg::ST_OCC1: begin
        occ_raddr   = nxt_site[SW-1:0];
        cmp_ctl.clr = 1'b1;
        if (op_r == lmks_pkg::OP_PLACE) begin
          if (occ_rdata[0] && !own) begin
            state_nxt = lmks_pkg::ST_DONE;
          end else begin
            // a bound particle leaves its old site first
            if (bound_cur) begin
              occ_we    = 1'b1;
              occ_waddr = pos_r;
              occ_wdata = 1'b0;
            end
            state_nxt = lmks_pkg::ST_PLACE;
          end
        end else begin
          occ0_nxt  = occ_rdata[0];
          state_nxt = lmks_pkg::ST_BIND;
        end
      end
      lmks_pkg::ST_PLACE: begin
        occ_we           = 1'b1;
        occ_waddr        = tgt_r;
        occ_wdata        = 1'b1;
        site_we          = 1'b1;
        site_wdata       = {1'b1, tgt_r};
        bnd_nxt          = 1'b1;
        pos_nxt          = tgt_r;
        ev_nxt           = lmks_pkg::EV_PLACE;
        state_nxt        = lmks_pkg::ST_DONE;
      end
      // bind threshold
      lmks_pkg::ST_BIND: begin
        occ1_nxt       = occ_rdata[0];
        cmp_ctl.add    = 1'b1;
        cmp_ctl.weight = (!bound_cur && !occ0_r) ? bind_w_r : '0;
        if (cmp_hit) begin
          ev_nxt    = lmks_pkg::EV_BIND;
          state_nxt = lmks_pkg::ST_APPLY;
        end else begin
          state_nxt = lmks_pkg::ST_UNBIND;
        end
      end
      // unbind threshold
      lmks_pkg::ST_UNBIND: begin
        cmp_ctl.add    = 1'b1;
        cmp_ctl.weight = bound_cur ? unbind_w_r : '0;
        if (cmp_hit) begin
          ev_nxt    = lmks_pkg::EV_UNBIND;
          state_nxt = lmks_pkg::ST_APPLY;
        end else begin
          state_nxt = lmks_pkg::ST_STEP;
        end
      end
      // step threshold
      lmks_pkg::ST_STEP: begin
        cmp_ctl.add    = 1'b1;
        cmp_ctl.weight = step_ok ? step_w_r : '0;
        if (cmp_hit) begin
          ev_nxt    = lmks_pkg::EV_STEP;
          state_nxt = lmks_pkg::ST_APPLY;
        end else begin
          state_nxt = lmks_pkg::ST_DONE;
        end
      end
      // write back the chosen outcome at the current site
      lmks_pkg::ST_APPLY: begin
        occ_we    = 1'b1;
        occ_waddr = pos_r;
        state_nxt = lmks_pkg::ST_DONE;
        case (ev_r)
          lmks_pkg::EV_BIND: begin
            occ_wdata  = 1'b1;
            site_we    = 1'b1;
            site_wdata = {1'b1, pos_r};
            bnd_nxt    = 1'b1;
          end
          lmks_pkg::EV_UNBIND: begin
            occ_wdata  = 1'b0;
            site_we    = 1'b1;
            site_wdata = {1'b0, pos_r};
            bnd_nxt    = 1'b0;
          end
          lmks_pkg::EV_STEP: begin
            occ_wdata = 1'b0;
            state_nxt = lmks_pkg::ST_STEP2;
          end
          default: begin
            occ_we = 1'b0;
          end
        endcase
      end
      // step lands on the next site
      lmks_pkg::ST_STEP2: begin
        occ_we     = 1'b1;
        occ_waddr  = nxt_site[SW-1:0];
        occ_wdata  = 1'b1;
        site_we    = 1'b1;
        site_wdata = {bnd_r, nxt_site[SW-1:0]};
        pos_nxt    = nxt_site[SW-1:0];
        state_nxt  = lmks_pkg::ST_DONE;
      end
      // hand the result over once the output register is free
      lmks_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = lmks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lmks_pkg::ST_IDLE;
      end
    endcase
  end

  // output valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmks_pkg::ST_CLEAR;
      clr_r       <= '0;
      ev_r        <= lmks_pkg::EV_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ev_r        <= ev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= lmks_pkg::op_t'(in_tuser[0]);
      p_r    <= in_tdata[7:0];
      tgt_r  <= in_tdata[20:8];
      draw_r <= in_tdata[40:21];
    end
    pos_r  <= pos_nxt;
    bnd_r  <= bnd_nxt;
    occ0_r <= occ0_nxt;
    occ1_r <= occ1_nxt;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_p_r   <= p_r;
      out_pos_r <= pos_r;
      out_bnd_r <= bnd_r;
      out_ev_r  <= ev_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_bnd_r, out_pos_r, out_p_r};
  assign out_tuser  = out_ev_r;

  // an accepted item always starts with the position fetch
  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == lmks_pkg::ST_FETCH))
    else $error("accepted item did not start with a fetch");

  // a finished result waits while the output register is still held
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmks_pkg::ST_DONE && out_valid_r && !out_tready)
    |=> (state_r == lmks_pkg::ST_DONE && out_valid_r))
    else $error("result overwrote a beat still waiting");

  // a completed place leaves the particle bound
  a_place_binds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmks_pkg::ST_PLACE) |=> (bnd_r && ev_r == lmks_pkg::EV_PLACE))
    else $error("place did not bind the particle");

  // no item is taken during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmks_pkg::ST_CLEAR) |-> !in_tready)
    else $error("input ready during occupancy sweep");

endmodule

`default_nettype wire

>>> src/lmks_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lmks_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/lmks_cmp_unit.sv
// shared accumulate and compare unit for the cumulative weight test
`timescale 1ns / 1ps
`default_nettype none

module lmks_cmp_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lmks_pkg::cmp_ctl_t          ctl,
  input  wire logic [lmks_pkg::DRAW_W-1:0] draw,
  output logic                             hit
);

  logic [lmks_pkg::ACC_W-1:0] acc_r;
  logic [lmks_pkg::ACC_W-1:0] acc_nxt;
  logic [lmks_pkg::ACC_W-1:0] sum;

  // running threshold plus the weight under test
  assign sum = acc_r + {{(lmks_pkg::ACC_W-lmks_pkg::WEIGHT_W){1'b0}}, ctl.weight};
  assign hit = {{(lmks_pkg::ACC_W-lmks_pkg::DRAW_W){1'b0}}, draw} < sum;

  // accumulator next value
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.add) begin
      acc_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> dv/lattice_motor_kinetic_step_core_test.sv
// self-checking regression for the lattice motor kinetic step core
`timescale 1ns / 1ps

module lattice_motor_kinetic_step_core_test;

  localparam int PW = lmks_pkg::PART_W;
  localparam int SW = lmks_pkg::SITE_W;
  localparam int WW = lmks_pkg::WEIGHT_W;
  localparam int DW = lmks_pkg::DRAW_W;
  localparam int LW = lmks_pkg::LEN_W;

  // one result beat split into its fields
  typedef struct {
    logic [PW-1:0] part;
    logic [SW-1:0] pos;
    logic          bnd;
    lmks_pkg::ev_t ev;
  } motor_result_t;

  // one row of the directed table: a register write or an item beat
  typedef struct {
    bit                 is_cfg;
    lmks_pkg::cfg_idx_t idx;
    logic [WW-1:0]      val;
    lmks_pkg::op_t      op;
    logic [PW-1:0]      part;
    logic [SW-1:0]      site;
    logic [DW-1:0]      draw;
    bit                 typed;
    motor_result_t      res;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;  // particle_index[7:0], site[20:8], random_draw[40:21]
  logic [0:0]  in_tuser   = '0;  // opcode[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // particle_out[7:0], position_out[20:8], bound_out[21]
  logic [2:0]  out_tuser;        // event_res[2:0]
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [19:0] cfg_data   = '0;

  // predicted lattice state and register copies
  bit [SW-1:0]     model_pos    [lmks_pkg::MAX_PARTICLES];
  bit              model_bound  [lmks_pkg::MAX_PARTICLES];
  bit              model_placed [lmks_pkg::MAX_PARTICLES];
  bit              model_occ    [lmks_pkg::LATTICE_SITES];
  int unsigned     placed_ids[$];
  int unsigned     bind_w   = 0;
  int unsigned     unbind_w = 0;
  int unsigned     step_w   = 0;
  int unsigned     lat_len  = 8192;

  motor_result_t expected_results[$];
  motor_result_t no_typed = '{part: '0, pos: '0, bnd: 1'b0, ev: lmks_pkg::EV_NONE};
  stim_row_t     dir_rows[$];
  bit            quiet = 1'b0;
  int            errors = 0;
  int            beats_sent = 0;
  int            ev_seen [5];

  lattice_motor_kinetic_step_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // place or kinetic update on the predicted lattice, returns the result beat
  function automatic motor_result_t step_motor(lmks_pkg::op_t op, logic [PW-1:0] p,
                                               logic [SW-1:0] tgt,
                                               logic [DW-1:0] draw);
    motor_result_t r;
    logic [SW-1:0] pos;
    logic [SW:0]   nxt;
    int unsigned   lim;
    int unsigned   thr_b;
    int unsigned   thr_u;
    int unsigned   thr_s;
    r.ev = lmks_pkg::EV_NONE;
    pos  = model_pos[p];
    if (op == lmks_pkg::OP_PLACE) begin
      // an occupied site is refused unless it is this particle's own bound site
      if (!model_occ[tgt] || (model_bound[p] && pos == tgt)) begin
        if (model_bound[p]) model_occ[pos] = 1'b0;
        if (!model_placed[p]) placed_ids.push_back(p);
        model_placed[p] = 1'b1;
        model_pos[p]    = tgt;
        model_bound[p]  = 1'b1;
        model_occ[tgt]  = 1'b1;
        r.ev = lmks_pkg::EV_PLACE;
      end
    end else begin
      nxt = {1'b0, pos} + 1'b1;
      lim = (lat_len > lmks_pkg::LATTICE_SITES) ? lmks_pkg::LATTICE_SITES : lat_len;
      thr_b = (!model_bound[p] && !model_occ[pos]) ? bind_w : 0;
      thr_u = model_bound[p] ? unbind_w : 0;
      thr_s = (model_bound[p] && nxt < lim && !model_occ[nxt[SW-1:0]]) ? step_w : 0;
      // cumulative thresholds
      thr_u = thr_u + thr_b;
      thr_s = thr_s + thr_u;
      if (draw < thr_b) begin
        model_bound[p] = 1'b1;
        model_occ[pos] = 1'b1;
        r.ev = lmks_pkg::EV_BIND;
      end else if (draw < thr_u) begin
        model_bound[p] = 1'b0;
        model_occ[pos] = 1'b0;
        r.ev = lmks_pkg::EV_UNBIND;
      end else if (draw < thr_s) begin
        model_occ[pos] = 1'b0;
        model_occ[nxt[SW-1:0]] = 1'b1;
        model_pos[p] = nxt[SW-1:0];
        r.ev = lmks_pkg::EV_STEP;
      end
    end
    r.part = p;
    r.pos  = model_pos[p];
    r.bnd  = model_bound[p];
    return r;
  endfunction

  function automatic void add_item(lmks_pkg::op_t op, int p, int s, int d, bit typed,
                                   int pos, bit bnd, lmks_pkg::ev_t ev);
    stim_row_t row;
    row.is_cfg   = 1'b0;
    row.idx      = lmks_pkg::CFG_BIND_WEIGHT;
    row.val      = '0;
    row.op       = op;
    row.part     = PW'(p);
    row.site     = SW'(s);
    row.draw     = DW'(d);
    row.typed    = typed;
    row.res.part = PW'(p);
    row.res.pos  = SW'(pos);
    row.res.bnd  = bnd;
    row.res.ev   = ev;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(lmks_pkg::cfg_idx_t idx, int val);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = WW'(val);
    row.op     = lmks_pkg::OP_PLACE;
    row.part   = '0;
    row.site   = '0;
    row.draw   = '0;
    row.typed  = 1'b0;
    row.res    = no_typed;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [WW-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 20'd1000000;
      2:       return 20'hFFFFF;
      default: return WW'($urandom_range(0, 400000));
    endcase
  endfunction

  // drop the input beat, then wait for every outstanding result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // register write while the core is idle
  task automatic write_reg(lmks_pkg::cfg_idx_t idx, logic [WW-1:0] val);
    wait_drained();
    repeat (12) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lmks_pkg::CFG_BIND_WEIGHT:    bind_w   = 32'(val);
      lmks_pkg::CFG_UNBIND_WEIGHT:  unbind_w = 32'(val);
      lmks_pkg::CFG_STEP_WEIGHT:    step_w   = 32'(val);
      lmks_pkg::CFG_LATTICE_LENGTH: lat_len  = 32'(val[LW-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one item beat with random idle cycles ahead of it unless quiet is set; called at a falling edge
  task automatic send_beat(lmks_pkg::op_t op, logic [PW-1:0] p, logic [SW-1:0] s,
                           logic [DW-1:0] d, bit typed, motor_result_t typed_res);
    motor_result_t r;
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, d, s, p};
    do @(posedge clk); while (!in_tready);
    r = step_motor(op, p, s, d);
    if (typed) expected_results.push_back(typed_res);
    else expected_results.push_back(r);
    beats_sent++;
    @(negedge clk);
  endtask

  // mostly crowded low sites so that particles collide and block each other
  task automatic send_random_beat();
    logic [PW-1:0] p;
    logic [SW-1:0] s;
    logic [DW-1:0] d;
    if (placed_ids.size() == 0 || $urandom_range(0, 99) < 25) begin
      p = ($urandom_range(0, 99) < 85) ? PW'($urandom_range(0, 39))
                                       : PW'($urandom_range(0, 255));
      s = ($urandom_range(0, 99) < 80) ? SW'($urandom_range(0, 63))
                                       : SW'($urandom_range(0, lmks_pkg::LATTICE_SITES - 1));
      // a refused place on a fresh particle would report a site never written
      if (!model_placed[p]) begin
        while (model_occ[s]) s = s + SW'(1);
      end
      d = DW'($urandom_range(0, 20'hFFFFF));
      send_beat(lmks_pkg::OP_PLACE, p, s, d, 1'b0, no_typed);
    end else begin
      p = PW'(placed_ids[$urandom_range(0, placed_ids.size() - 1)]);
      s = SW'($urandom_range(0, lmks_pkg::LATTICE_SITES - 1));
      d = ($urandom_range(0, 99) < 85) ? DW'($urandom_range(0, 1000000))
                                       : DW'($urandom_range(0, 20'hFFFFF));
      send_beat(lmks_pkg::OP_UPDATE, p, s, d, 1'b0, no_typed);
    end
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    out_tready <= quiet || ($urandom_range(0, 99) >= 10);
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    motor_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result beat, expected none actual tdata %h tuser %0d",
                 $time, out_tdata, out_tuser);
      end else begin
        want = expected_results.pop_front();
        check_field("particle_out", want.part, out_tdata[7:0]);
        check_field("position_out", want.pos, out_tdata[20:8]);
        check_field("bound_out", want.bnd, out_tdata[21]);
        check_field("event_res", want.ev, out_tuser);
        if (out_tuser <= lmks_pkg::EV_PLACE) ev_seen[out_tuser]++;
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        k;
    // directed table, reset weights all zero and full lattice
    add_item(lmks_pkg::OP_PLACE,    0,    0,       0, 1'b1,    0, 1'b1, lmks_pkg::EV_PLACE);
    add_item(lmks_pkg::OP_PLACE,  255, 8191,       0, 1'b1, 8191, 1'b1, lmks_pkg::EV_PLACE);
    add_item(lmks_pkg::OP_UPDATE, 255,    0,       0, 1'b1, 8191, 1'b1, lmks_pkg::EV_NONE);
    add_item(lmks_pkg::OP_PLACE,    1,    5,       0, 1'b1,    5, 1'b1, lmks_pkg::EV_PLACE);
    // site held by another particle
    add_item(lmks_pkg::OP_PLACE,    1,    0,       0, 1'b1,    5, 1'b1, lmks_pkg::EV_NONE);
    // own bound site is accepted
    add_item(lmks_pkg::OP_PLACE,    0,    0,       0, 1'b1,    0, 1'b1, lmks_pkg::EV_PLACE);
    // moving a bound particle frees its old site
    add_item(lmks_pkg::OP_PLACE,    0,   10,       0, 1'b1,   10, 1'b1, lmks_pkg::EV_PLACE);
    add_item(lmks_pkg::OP_PLACE,    1,    0,       0, 1'b1,    0, 1'b1, lmks_pkg::EV_PLACE);
    add_cfg(lmks_pkg::CFG_UNBIND_WEIGHT, 1000000);
    add_item(lmks_pkg::OP_UPDATE,   0,    0,       0, 1'b1,   10, 1'b0, lmks_pkg::EV_UNBIND);
    add_item(lmks_pkg::OP_UPDATE,   0,    0, 1000000, 1'b1,   10, 1'b0, lmks_pkg::EV_NONE);
    add_cfg(lmks_pkg::CFG_BIND_WEIGHT, 1000000);
    add_item(lmks_pkg::OP_UPDATE,   0,    0,  999999, 1'b1,   10, 1'b1, lmks_pkg::EV_BIND);
    add_cfg(lmks_pkg::CFG_BIND_WEIGHT, 0);
    add_cfg(lmks_pkg::CFG_UNBIND_WEIGHT, 0);
    add_cfg(lmks_pkg::CFG_STEP_WEIGHT, 1000000);
    add_item(lmks_pkg::OP_UPDATE,   0,    0,       0, 1'b1,   11, 1'b1, lmks_pkg::EV_STEP);
    // last site of the array cannot step
    add_item(lmks_pkg::OP_UPDATE, 255,    0,       0, 1'b1, 8191, 1'b1, lmks_pkg::EV_NONE);
    add_cfg(lmks_pkg::CFG_LATTICE_LENGTH, 12);
    add_item(lmks_pkg::OP_UPDATE,   0,    0,       0, 1'b1,   11, 1'b1, lmks_pkg::EV_NONE);
    // zero length allows no steps
    add_cfg(lmks_pkg::CFG_LATTICE_LENGTH, 0);
    add_item(lmks_pkg::OP_UPDATE,   0,    0,       0, 1'b1,   11, 1'b1, lmks_pkg::EV_NONE);
    // length above the array is clipped
    add_cfg(lmks_pkg::CFG_LATTICE_LENGTH, 16383);
    add_item(lmks_pkg::OP_UPDATE,   0,    0,       0, 1'b1,   12, 1'b1, lmks_pkg::EV_STEP);
    add_item(lmks_pkg::OP_PLACE,    1,   13,       0, 1'b1,   13, 1'b1, lmks_pkg::EV_PLACE);
    // next site occupied
    add_item(lmks_pkg::OP_UPDATE,   0,    0,       0, 1'b1,   12, 1'b1, lmks_pkg::EV_NONE);
    // draw above the span against the largest weight
    add_cfg(lmks_pkg::CFG_STEP_WEIGHT, 20'hFFFFF);
    add_item(lmks_pkg::OP_UPDATE,   1, 8191, 20'hFFFFF, 1'b1, 13, 1'b1, lmks_pkg::EV_NONE);
    add_cfg(lmks_pkg::CFG_UNBIND_WEIGHT, 1000000);
    add_cfg(lmks_pkg::CFG_STEP_WEIGHT, 0);
    add_item(lmks_pkg::OP_PLACE,    2,   20,       0, 1'b1,   20, 1'b1, lmks_pkg::EV_PLACE);
    add_item(lmks_pkg::OP_UPDATE,   2,    0,       0, 1'b1,   20, 1'b0, lmks_pkg::EV_UNBIND);
    add_item(lmks_pkg::OP_PLACE,    3,   20,       0, 1'b1,   20, 1'b1, lmks_pkg::EV_PLACE);
    // unbound particle on a site taken by another cannot bind
    add_cfg(lmks_pkg::CFG_BIND_WEIGHT, 1000000);
    add_cfg(lmks_pkg::CFG_UNBIND_WEIGHT, 0);
    add_item(lmks_pkg::OP_UPDATE,   2,    0,       0, 1'b1,   20, 1'b0, lmks_pkg::EV_NONE);
    // mixed weights, draw falls in the step band
    add_cfg(lmks_pkg::CFG_BIND_WEIGHT, 300000);
    add_cfg(lmks_pkg::CFG_UNBIND_WEIGHT, 300000);
    add_cfg(lmks_pkg::CFG_STEP_WEIGHT, 300000);
    add_item(lmks_pkg::OP_UPDATE,   1,    0,  450000, 1'b0,    0, 1'b0, lmks_pkg::EV_NONE);

    // synchronous reset, released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) write_reg(row.idx, row.val);
      else send_beat(row.op, row.part, row.site, row.draw, row.typed, row.res);
    end

    // random phases, each under its own register settings
    for (int phase = 0; phase < 8; phase++) begin
      quiet = (phase == 3);
      write_reg(lmks_pkg::CFG_BIND_WEIGHT, pick_weight());
      write_reg(lmks_pkg::CFG_UNBIND_WEIGHT, pick_weight());
      write_reg(lmks_pkg::CFG_STEP_WEIGHT, pick_weight());
      case ($urandom_range(0, 6))
        0:       write_reg(lmks_pkg::CFG_LATTICE_LENGTH, 0);
        1:       write_reg(lmks_pkg::CFG_LATTICE_LENGTH, 1);
        2:       write_reg(lmks_pkg::CFG_LATTICE_LENGTH, 8192);
        3:       write_reg(lmks_pkg::CFG_LATTICE_LENGTH, 16383);
        4:       write_reg(lmks_pkg::CFG_LATTICE_LENGTH, WW'($urandom_range(0, 16383)));
        default: write_reg(lmks_pkg::CFG_LATTICE_LENGTH, WW'($urandom_range(2, 64)));
      endcase
      for (k = 0; k < 240; k++) begin
        // now and then hold off until every result is back
        if ($urandom_range(0, 149) == 0) wait_drained();
        send_random_beat();
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t ns: results missing, expected %0d more actual 0", $time,
               expected_results.size());
    end
    $display("ran %0d item beats: directed table plus 8 random register settings", beats_sent);
    $display("events: placed %0d bound %0d unbound %0d stepped %0d nothing %0d",
             ev_seen[lmks_pkg::EV_PLACE], ev_seen[lmks_pkg::EV_BIND],
             ev_seen[lmks_pkg::EV_UNBIND], ev_seen[lmks_pkg::EV_STEP],
             ev_seen[lmks_pkg::EV_NONE]);
    if (errors == 0) begin
      $display("lattice_motor_kinetic_step_core regression: pass");
    end else begin
      $display("lattice_motor_kinetic_step_core regression: fail");
    end
    $finish;
  end

  // watchdog on the whole run
  initial begin : watchdog
    #1000000;
    $display("lattice_motor_kinetic_step_core regression: fail");
    $finish;
  end

endmodule

>>> sim.f
src/lmks_pkg.sv
src/lmks_ram.sv
src/lmks_cmp_unit.sv
src/lattice_motor_kinetic_step_core.sv
dv/lattice_motor_kinetic_step_core_test.sv
